// ===== sv/pwbfs_pkg.sv =====
// shared types and constants for the pulse width button frame sender
// no dependencies

package pwbfs_pkg;

	localparam int unsigned PERIOD_W = 20;
	localparam int unsigned TICKS_W  = 16;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_LOW_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_GAP_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW_TICKS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW_TICKS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_GAP_TICKS   = 3'd5;

	localparam logic [PERIOD_W-1:0] RST_FRAME_PERIOD    = 20'd50000;
	localparam logic [TICKS_W-1:0]  RST_START_LOW_TICKS = 16'd3000;
	localparam logic [TICKS_W-1:0]  RST_START_GAP_TICKS = 16'd2000;
	localparam logic [TICKS_W-1:0]  RST_ZERO_LOW_TICKS  = 16'd400;
	localparam logic [TICKS_W-1:0]  RST_ONE_LOW_TICKS   = 16'd1600;
	localparam logic [TICKS_W-1:0]  RST_BIT_GAP_TICKS   = 16'd800;

	typedef struct packed {
		logic first_button_level;
		logic second_button_level;
		logic third_button_level;
	} tick_t;

	typedef struct packed {
		logic line_level;
		logic frame_busy;
	} line_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] frame_period;
		logic [TICKS_W-1:0]  start_low_ticks;
		logic [TICKS_W-1:0]  start_gap_ticks;
		logic [TICKS_W-1:0]  zero_low_ticks;
		logic [TICKS_W-1:0]  one_low_ticks;
		logic [TICKS_W-1:0]  bit_gap_ticks;
	} cfg_regs_t;

endpackage

// ===== sv/pwbfs_cfg.sv =====
// configuration register file, one write port
// depends on pwbfs_pkg

module pwbfs_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pwbfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pwbfs_pkg::PERIOD_W-1:0]      cfg_data,
	output pwbfs_pkg::cfg_regs_t                regs
);

	pwbfs_pkg::cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.frame_period    <= pwbfs_pkg::RST_FRAME_PERIOD;
			regs_q.start_low_ticks <= pwbfs_pkg::RST_START_LOW_TICKS;
			regs_q.start_gap_ticks <= pwbfs_pkg::RST_START_GAP_TICKS;
			regs_q.zero_low_ticks  <= pwbfs_pkg::RST_ZERO_LOW_TICKS;
			regs_q.one_low_ticks   <= pwbfs_pkg::RST_ONE_LOW_TICKS;
			regs_q.bit_gap_ticks   <= pwbfs_pkg::RST_BIT_GAP_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pwbfs_pkg::CFG_FRAME_PERIOD: begin
					regs_q.frame_period <= cfg_data;
				end
				pwbfs_pkg::CFG_START_LOW_TICKS: begin
					regs_q.start_low_ticks <= cfg_data[pwbfs_pkg::TICKS_W-1:0];
				end
				pwbfs_pkg::CFG_START_GAP_TICKS: begin
					regs_q.start_gap_ticks <= cfg_data[pwbfs_pkg::TICKS_W-1:0];
				end
				pwbfs_pkg::CFG_ZERO_LOW_TICKS: begin
					regs_q.zero_low_ticks <= cfg_data[pwbfs_pkg::TICKS_W-1:0];
				end
				pwbfs_pkg::CFG_ONE_LOW_TICKS: begin
					regs_q.one_low_ticks <= cfg_data[pwbfs_pkg::TICKS_W-1:0];
				end
				pwbfs_pkg::CFG_BIT_GAP_TICKS: begin
					regs_q.bit_gap_ticks <= cfg_data[pwbfs_pkg::TICKS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/pwbfs_core.sv =====
// frame timing state and per-tick line level logic
// depends on pwbfs_pkg

module pwbfs_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  pwbfs_pkg::tick_t     tick,
	input  pwbfs_pkg::cfg_regs_t regs,
	output pwbfs_pkg::line_t     result
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START_LOW,
		PH_START_GAP,
		PH_BIT_LOW,
		PH_BIT_GAP
	} phase_t;

	phase_t                         phase_q;
	logic [pwbfs_pkg::PERIOD_W-1:0] period_count_q;
	logic [pwbfs_pkg::TICKS_W-1:0]  phase_count_q;
	logic [1:0]                     bit_index_q;
	logic [2:0]                     buttons_q;

	logic                           start;
	phase_t                         ph;
	logic [pwbfs_pkg::TICKS_W-1:0]  pcnt;
	logic [1:0]                     bidx;
	logic [2:0]                     btn;
	logic                           bit_val;
	logic [pwbfs_pkg::TICKS_W-1:0]  len;
	logic [pwbfs_pkg::TICKS_W:0]    pcnt_inc;
	logic                           done;
	phase_t                         phase_d;
	logic [pwbfs_pkg::PERIOD_W-1:0] period_count_d;
	logic [pwbfs_pkg::TICKS_W-1:0]  phase_count_d;
	logic [1:0]                     bidx_d;

	assign start = (phase_q == PH_IDLE) && (period_count_q >= regs.frame_period);

	always_comb begin
		if (start) begin
			ph             = PH_START_LOW;
			pcnt           = '0;
			bidx           = 2'd0;
			btn            = {~tick.third_button_level, ~tick.second_button_level,
				~tick.first_button_level};
			period_count_d = '0;
		end else begin
			ph   = phase_q;
			pcnt = phase_count_q;
			bidx = bit_index_q;
			btn  = buttons_q;
			if (period_count_q != pwbfs_pkg::PERIOD_MAX) begin
				period_count_d = period_count_q + 1'b1;
			end else begin
				period_count_d = period_count_q;
			end
		end
	end

	// parity bit sent last
	always_comb begin
		case (bidx)
			2'd0:    bit_val = btn[0];
			2'd1:    bit_val = btn[1];
			2'd2:    bit_val = btn[2];
			default: bit_val = ^btn;
		endcase
	end

	always_comb begin
		case (ph)
			PH_START_LOW: len = regs.start_low_ticks;
			PH_START_GAP: len = regs.start_gap_ticks;
			PH_BIT_LOW:   len = bit_val ? regs.one_low_ticks : regs.zero_low_ticks;
			default:      len = regs.bit_gap_ticks;
		endcase
	end

	// a zero length compares as one since the incremented count is at least one
	assign pcnt_inc = {1'b0, pcnt} + 1'b1;
	assign done     = pcnt_inc >= {1'b0, len};

	always_comb begin
		phase_d       = ph;
		phase_count_d = pcnt;
		bidx_d        = bidx;
		result.line_level = 1'b1;
		result.frame_busy = 1'b0;
		if (ph != PH_IDLE) begin
			result.line_level = !((ph == PH_START_LOW) || (ph == PH_BIT_LOW));
			result.frame_busy = 1'b1;
			if (done) begin
				phase_count_d = '0;
				case (ph)
					PH_START_LOW: phase_d = PH_START_GAP;
					PH_START_GAP: begin
						phase_d = PH_BIT_LOW;
						bidx_d  = 2'd0;
					end
					PH_BIT_LOW:   phase_d = PH_BIT_GAP;
					default: begin
						if (bidx == 2'd3) begin
							phase_d = PH_IDLE;
							bidx_d  = 2'd0;
						end else begin
							phase_d = PH_BIT_LOW;
							bidx_d  = bidx + 2'd1;
						end
					end
				endcase
			end else begin
				phase_count_d = pcnt_inc[pwbfs_pkg::TICKS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			period_count_q <= '0;
			phase_count_q  <= '0;
			bit_index_q    <= 2'd0;
			buttons_q      <= 3'd0;
		end else if (accept) begin
			phase_q        <= phase_d;
			period_count_q <= period_count_d;
			phase_count_q  <= phase_count_d;
			bit_index_q    <= bidx_d;
			buttons_q      <= btn;
		end
	end

endmodule

// ===== sv/pwbfs_out.sv =====
// result register between the frame logic and the line channel
// depends on pwbfs_pkg

module pwbfs_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  pwbfs_pkg::line_t result,
	output logic             full_stalled,
	output logic             line_valid,
	input  logic             line_stall,
	output pwbfs_pkg::line_t line_data
);

	logic             valid_q;
	pwbfs_pkg::line_t data_q;

	assign full_stalled = valid_q && line_stall;
	assign line_valid   = valid_q;
	assign line_data    = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!line_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

// ===== sv/pulse_width_button_frame_sender.sv =====
// top level of the pulse width button frame sender
// depends on pwbfs_pkg, pwbfs_cfg, pwbfs_core, pwbfs_out
//
// channel  | handshake              | payload
// tick     | tick_valid/tick_stall  | tick_data  (three raw button levels)
// line     | line_valid/line_stall  | line_data  (line level, busy flag)
// cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// one tick is taken per cycle unless stalled; its result is registered for the
// next cycle. the state update is a single pass of compare and increment logic.
// tick_stall is high only while a result sits in the register and the line side
// stalls. reset restores the default timing registers and goes idle.

module pulse_width_button_frame_sender (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick_valid,
	output logic                            tick_stall,
	input  pwbfs_pkg::tick_t                tick_data,
	output logic                            line_valid,
	input  logic                            line_stall,
	output pwbfs_pkg::line_t                line_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pwbfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pwbfs_pkg::PERIOD_W-1:0]  cfg_data
);

	pwbfs_pkg::cfg_regs_t regs;
	pwbfs_pkg::line_t     result;
	logic                 accept;
	logic                 full_stalled;

	assign tick_stall = full_stalled;
	assign accept     = tick_valid && !full_stalled;

	pwbfs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	pwbfs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.tick   (tick_data),
		.regs   (regs),
		.result (result)
	);

	pwbfs_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.result       (result),
		.full_stalled (full_stalled),
		.line_valid   (line_valid),
		.line_stall   (line_stall),
		.line_data    (line_data)
	);

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for pulse_width_button_frame_sender
// predicts line level and busy per tick transaction and compares in order
// depends on pwbfs_pkg and the rtl under sv/

module testbench;

	typedef logic [pwbfs_pkg::PERIOD_W-1:0] period_t;

	localparam logic [pwbfs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [pwbfs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum logic [2:0] {
		SEND_IDLE,
		SYNC_LOW,
		SYNC_SPACE,
		BIT_PULSE,
		BIT_GAP
	} send_phase_e;

	class line_scoreboard;
		logic [pwbfs_pkg::PERIOD_W-1:0] frame_period;
		logic [pwbfs_pkg::TICKS_W-1:0]  start_low;
		logic [pwbfs_pkg::TICKS_W-1:0]  start_space;
		logic [pwbfs_pkg::TICKS_W-1:0]  zero_low;
		logic [pwbfs_pkg::TICKS_W-1:0]  one_low;
		logic [pwbfs_pkg::TICKS_W-1:0]  bit_gap;
		logic [pwbfs_pkg::PERIOD_W-1:0] since_start;
		send_phase_e                    phase;
		logic [pwbfs_pkg::TICKS_W-1:0]  phase_ticks;
		logic [1:0]                     bit_sel;
		logic [2:0]                     pressed;
		pwbfs_pkg::line_t               expected_lines[$];
		int                             results_seen;
		int                             errors;

		function new();
			frame_period = pwbfs_pkg::RST_FRAME_PERIOD;
			start_low    = pwbfs_pkg::RST_START_LOW_TICKS;
			start_space  = pwbfs_pkg::RST_START_GAP_TICKS;
			zero_low     = pwbfs_pkg::RST_ZERO_LOW_TICKS;
			one_low      = pwbfs_pkg::RST_ONE_LOW_TICKS;
			bit_gap      = pwbfs_pkg::RST_BIT_GAP_TICKS;
			since_start  = '0;
			phase        = SEND_IDLE;
			phase_ticks  = '0;
			bit_sel      = '0;
			pressed      = '0;
			results_seen = 0;
			errors       = 0;
		endfunction

		function void write_reg(logic [pwbfs_pkg::CFG_IDX_W-1:0] idx,
			logic [pwbfs_pkg::PERIOD_W-1:0] data);
			case (idx)
			pwbfs_pkg::CFG_FRAME_PERIOD:    frame_period = data;
			pwbfs_pkg::CFG_START_LOW_TICKS: start_low = data[pwbfs_pkg::TICKS_W-1:0];
			pwbfs_pkg::CFG_START_GAP_TICKS: start_space = data[pwbfs_pkg::TICKS_W-1:0];
			pwbfs_pkg::CFG_ZERO_LOW_TICKS:  zero_low = data[pwbfs_pkg::TICKS_W-1:0];
			pwbfs_pkg::CFG_ONE_LOW_TICKS:   one_low = data[pwbfs_pkg::TICKS_W-1:0];
			pwbfs_pkg::CFG_BIT_GAP_TICKS:   bit_gap = data[pwbfs_pkg::TICKS_W-1:0];
			default: ;
			endcase
		endfunction

		function int unsigned phase_len();
			logic [pwbfs_pkg::TICKS_W-1:0] len;
			logic                          bit_val;
			bit_val = (bit_sel == 2'd3) ? ^pressed : pressed[bit_sel];
			case (phase)
			SYNC_LOW:   len = start_low;
			SYNC_SPACE: len = start_space;
			BIT_PULSE:  len = bit_val ? one_low : zero_low;
			default:    len = bit_gap;
			endcase
			// a zero length still lasts one tick
			return (len == '0) ? 1 : int'(len);
		endfunction

		function void note_tick(pwbfs_pkg::tick_t t);
			pwbfs_pkg::line_t want;
			if (phase == SEND_IDLE && since_start >= frame_period) begin
				pressed     = ~{t.third_button_level, t.second_button_level,
					t.first_button_level};
				since_start = '0;
				phase       = SYNC_LOW;
				phase_ticks = '0;
				bit_sel     = '0;
			end else if (since_start != pwbfs_pkg::PERIOD_MAX) begin
				since_start++;
			end
			want.line_level = !(phase == SYNC_LOW || phase == BIT_PULSE);
			want.frame_busy = (phase != SEND_IDLE);
			if (phase != SEND_IDLE) begin
				if (int'(phase_ticks) + 1 >= phase_len()) begin
					phase_ticks = '0;
					case (phase)
					SYNC_LOW: phase = SYNC_SPACE;
					SYNC_SPACE: begin
						phase   = BIT_PULSE;
						bit_sel = '0;
					end
					BIT_PULSE: phase = BIT_GAP;
					default: begin
						if (bit_sel == 2'd3) begin
							phase   = SEND_IDLE;
							bit_sel = '0;
						end else begin
							bit_sel++;
							phase = BIT_PULSE;
						end
					end
					endcase
				end else begin
					phase_ticks++;
				end
			end
			expected_lines.push_back(want);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 200) begin
				$display("line mismatch at result %0d: %s", results_seen, what);
			end
		endtask

		task check_line(pwbfs_pkg::line_t got);
			pwbfs_pkg::line_t want;
			results_seen++;
			if (expected_lines.size() == 0) begin
				report($sformatf("result %b arrived with nothing expected", got));
				return;
			end
			want = expected_lines.pop_front();
			if (got.line_level !== want.line_level) begin
				report($sformatf("line_level %b, expected %b", got.line_level,
					want.line_level));
			end
			if (got.frame_busy !== want.frame_busy) begin
				report($sformatf("frame_busy %b, expected %b", got.frame_busy,
					want.frame_busy));
			end
		endtask
	endclass

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                tick_valid = 1'b0;
	logic                                tick_stall;
	pwbfs_pkg::tick_t                    tick_data = '1;
	logic                                line_valid;
	logic                                line_stall = 1'b0;
	pwbfs_pkg::line_t                    line_data;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [pwbfs_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [pwbfs_pkg::PERIOD_W-1:0]      cfg_data = '0;

	logic                                quiet = 1'b0;
	int                                  stall_left = 0;
	line_scoreboard                      sb;

	pulse_width_button_frame_sender u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick_data  (tick_data),
		.line_valid (line_valid),
		.line_stall (line_stall),
		.line_data  (line_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 500000);
		$display("pulse_width_button_frame_sender regression: fail");
		$finish;
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (quiet) begin
			line_stall <= 1'b0;
		end else if (stall_left > 0) begin
			line_stall <= 1'b1;
			stall_left--;
		end else begin
			line_stall <= 1'b0;
			if ($urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 10);
			end
		end
	end

	// transaction monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
			end
			if (tick_valid && !tick_stall) begin
				sb.note_tick(tick_data);
			end
			if (line_valid && !line_stall) begin
				sb.check_line(line_data);
			end
		end
	end

	task automatic push_tick(pwbfs_pkg::tick_t t);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		tick_valid <= 1'b1;
		tick_data  <= t;
		do @(posedge clk); while (tick_stall);
	endtask

	task automatic set_reg(logic [pwbfs_pkg::CFG_IDX_W-1:0] idx,
		logic [pwbfs_pkg::PERIOD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic settle();
		tick_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_lines.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic send_random_ticks(int count);
		cfg_valid <= 1'b0;
		repeat (count) push_tick(pwbfs_pkg::tick_t'($urandom_range(0, 7)));
		settle();
	endtask

	function automatic logic [pwbfs_pkg::PERIOD_W-1:0] pick_ticks();
		logic [3:0] upper;
		upper = 4'($urandom);
		case ($urandom_range(0, 9))
		0:       return {upper, 16'd0};
		1:       return {upper, 16'($urandom_range(9, 40))};
		default: return {upper, 16'($urandom_range(1, 8))};
		endcase
	endfunction

	function automatic logic [pwbfs_pkg::PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 7))
		0:       return '0;
		1:       return period_t'($urandom_range(13, 60));
		default: return period_t'($urandom_range(1, 12));
		endcase
	endfunction

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: idle line, no frame for a long time
		send_random_ticks(3);

		// zero period, zero start low and bit gap lengths, no buttons then all buttons pressed
		set_reg(pwbfs_pkg::CFG_FRAME_PERIOD, '0);
		set_reg(pwbfs_pkg::CFG_START_LOW_TICKS, '0);
		set_reg(pwbfs_pkg::CFG_START_GAP_TICKS, 20'd1);
		set_reg(pwbfs_pkg::CFG_ZERO_LOW_TICKS, 20'd1);
		set_reg(pwbfs_pkg::CFG_ONE_LOW_TICKS, 20'd2);
		set_reg(pwbfs_pkg::CFG_BIT_GAP_TICKS, '0);
		cfg_valid <= 1'b0;
		for (int k = 0; k < 16; k++) begin
			if (k == 0) begin
				push_tick(pwbfs_pkg::tick_t'(3'b111));
			end else if (k == 10) begin
				push_tick(pwbfs_pkg::tick_t'(3'b000));
			end else begin
				push_tick(pwbfs_pkg::tick_t'($urandom_range(0, 7)));
			end
		end
		settle();

		// largest values land in the middle of a frame
		set_reg(pwbfs_pkg::CFG_FRAME_PERIOD, pwbfs_pkg::PERIOD_MAX);
		set_reg(pwbfs_pkg::CFG_START_LOW_TICKS, 20'hFFFFF);
		set_reg(pwbfs_pkg::CFG_START_GAP_TICKS, 20'hFFFFF);
		set_reg(pwbfs_pkg::CFG_ZERO_LOW_TICKS, 20'hFFFFF);
		set_reg(pwbfs_pkg::CFG_ONE_LOW_TICKS, 20'hFFFFF);
		set_reg(pwbfs_pkg::CFG_BIT_GAP_TICKS, 20'hFFFFF);
		send_random_ticks(3);

		// shrinking lengths cut the running phase short
		set_reg(pwbfs_pkg::CFG_FRAME_PERIOD, 20'd1);
		set_reg(pwbfs_pkg::CFG_START_LOW_TICKS, 20'd1);
		set_reg(pwbfs_pkg::CFG_START_GAP_TICKS, 20'd1);
		set_reg(pwbfs_pkg::CFG_ZERO_LOW_TICKS, 20'd1);
		set_reg(pwbfs_pkg::CFG_ONE_LOW_TICKS, 20'd1);
		set_reg(pwbfs_pkg::CFG_BIT_GAP_TICKS, 20'd1);
		send_random_ticks(3);

		for (int p = 0; p < 10; p++) begin
			if ($urandom_range(0, 1)) set_reg(pwbfs_pkg::CFG_FRAME_PERIOD, pick_period());
			if ($urandom_range(0, 1)) set_reg(pwbfs_pkg::CFG_START_LOW_TICKS, pick_ticks());
			if ($urandom_range(0, 1)) set_reg(pwbfs_pkg::CFG_START_GAP_TICKS, pick_ticks());
			if ($urandom_range(0, 1)) set_reg(pwbfs_pkg::CFG_ZERO_LOW_TICKS, pick_ticks());
			if ($urandom_range(0, 1)) set_reg(pwbfs_pkg::CFG_ONE_LOW_TICKS, pick_ticks());
			if ($urandom_range(0, 1)) set_reg(pwbfs_pkg::CFG_BIT_GAP_TICKS, pick_ticks());
			if ($urandom_range(0, 3) == 0) begin
				set_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
					period_t'($urandom));
			end
			send_random_ticks($urandom_range(35, 55));
		end

		// back to back with no idling on either side
		quiet <= 1'b1;
		set_reg(pwbfs_pkg::CFG_FRAME_PERIOD, pick_period());
		set_reg(pwbfs_pkg::CFG_ONE_LOW_TICKS, pick_ticks());
		send_random_ticks(50);

		if (sb.errors == 0) begin
			$display("pulse_width_button_frame_sender regression: pass");
		end else begin
			$display("pulse_width_button_frame_sender regression: fail");
		end
		$finish;
	end

endmodule
